// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define TGAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tgad assertion failed");

// Next-cycle implication, switched off while reset is low.
`define TGAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tgad assertion failed");

`endif

// File: rtl/tgad_pkg.sv
// Package for the TGA true-colour stream decoder: result kinds, parse phases,
// header byte positions and widths. No dependencies.
package tgad_pkg;

    // Result kinds, carried on m_axis_tuser
    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_PIXEL     = 2'd1;
    localparam logic [1:0] KIND_BAD_TYPE  = 2'd2;
    localparam logic [1:0] KIND_BAD_DEPTH = 2'd3;

    // Parse phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXELS = 2'd1;
    localparam logic [1:0] PH_IDLE   = 2'd2;

    // Header byte positions
    localparam logic [4:0] POS_CMAP_TYPE = 5'd1;
    localparam logic [4:0] POS_IMG_TYPE  = 5'd2;
    localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] POS_DEPTH     = 5'd16;
    localparam logic [4:0] POS_JUDGE     = 5'd17;

    localparam logic [7:0] CMAP_NONE      = 8'd0;
    localparam logic [7:0] IMG_TRUECOLOUR = 8'd2;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR    = 8'd0;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_ENABLE = 2'd0;
    localparam logic [1:0] CFG_KEY_RED    = 2'd1;
    localparam logic [1:0] CFG_KEY_GREEN  = 2'd2;
    localparam logic [1:0] CFG_KEY_BLUE   = 2'd3;

    localparam int OUT_TDATA_W = 80;

    // One result, before packing onto the master side
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
        logic        has_alpha;
        logic        last;
    } result_t;

endpackage

// File: rtl/tga_truecolor_stream_decoder_core.sv
// Top level of the TGA uncompressed true-colour stream decoder.
// Depends on tgad_pkg.
//
// Parses a TGA file arriving one byte per transfer on the slave side (tuser
// marks the first byte of a file and restarts parsing), checks the 18-byte
// header (colour-map type 0, image type 2, depth 24 or 32), then turns the
// BGR or BGRA pixel bytes into RGB with alpha. Each header gives one result:
// a header result, or a reject with tlast set, after which bytes are dropped
// until the next first flag. Each complete pixel gives one pixel result, the
// final one with tlast set. For 24-bit images the alpha is 0 on a match with
// the enabled colour key and 255 otherwise. The ID field is not skipped.
// Rate: one byte per clock cycle unless stalled. All per-byte work (a header
// counter step, a byte merge, one 16x16 multiply for the pixel count, a key
// compare) sits between the parse state registers and a single output
// register, so a result appears on the master side in the cycle after the
// byte that completes it. s_axis_tready drops only while a result waits in the
// output register and m_axis_tready is low. Configuration writes take effect
// at the next edge; write them only while the block is idle.
module tga_truecolor_stream_decoder_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [7:0]                         cfg_data,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
    input  logic                               s_axis_tuser,   // [0] first
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [47:32] width,
    // [63:48] height, [71:64] depth, [72] has_alpha, [79:73] zero
    output logic [tgad_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,   // [1:0] kind
    output logic                               m_axis_tlast
);
    import tgad_pkg::*;

    // Configuration registers
    logic        key_enable_reg;
    logic [7:0]  key_red_reg;
    logic [7:0]  key_green_reg;
    logic [7:0]  key_blue_reg;

    // Parse state
    logic [1:0]  phase_reg,      phase_next;
    logic [4:0]  pos_reg,        pos_next;
    logic [7:0]  cmap_type_reg,  cmap_type_next;
    logic [7:0]  img_type_reg,   img_type_next;
    logic [15:0] width_reg,      width_next;
    logic [15:0] height_reg,     height_next;
    logic [7:0]  depth_reg,      depth_next;
    logic [1:0]  bip_reg,        bip_next;
    logic [23:0] partial_reg,    partial_next;
    logic [31:0] pix_left_reg,   pix_left_next;

    // Output register
    logic        out_valid_reg,  out_valid_next;
    result_t     out_res_reg;

    // Parse state as seen by this byte: a first flag starts from cleared state
    logic [1:0]  ph_cur;
    logic [4:0]  pos_cur;
    logic [7:0]  cmap_cur;
    logic [7:0]  img_cur;
    logic [15:0] width_cur;
    logic [15:0] height_cur;
    logic [7:0]  depth_cur;
    logic [1:0]  bip_cur;
    logic [23:0] partial_cur;
    logic [31:0] pix_left_cur;

    logic        accept;
    logic        emit;
    result_t     res;
    logic        wide;
    logic        key_hit;
    logic [31:0] pix_count;
    logic [31:0] pix_dec;
    logic [7:0]  byte_in;

    assign byte_in = s_axis_tdata;
    assign accept  = s_axis_tvalid && s_axis_tready;

    // Accept while the output register is free or draining this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_enable_reg <= 1'b0;
            key_red_reg    <= 8'd0;
            key_green_reg  <= 8'd0;
            key_blue_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_ENABLE: key_enable_reg <= cfg_data[0];
                CFG_KEY_RED:    key_red_reg    <= cfg_data;
                CFG_KEY_GREEN:  key_green_reg  <= cfg_data;
                CFG_KEY_BLUE:   key_blue_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Restart from cleared parse state on a first flag
    always_comb
    begin
        if (s_axis_tuser)
        begin
            ph_cur       = PH_HEADER;
            pos_cur      = 5'd0;
            cmap_cur     = 8'd0;
            img_cur      = 8'd0;
            width_cur    = 16'd0;
            height_cur   = 16'd0;
            depth_cur    = 8'd0;
            bip_cur      = 2'd0;
            partial_cur  = 24'd0;
            pix_left_cur = 32'd0;
        end
        else
        begin
            ph_cur       = phase_reg;
            pos_cur      = pos_reg;
            cmap_cur     = cmap_type_reg;
            img_cur      = img_type_reg;
            width_cur    = width_reg;
            height_cur   = height_reg;
            depth_cur    = depth_reg;
            bip_cur      = bip_reg;
            partial_cur  = partial_reg;
            pix_left_cur = pix_left_reg;
        end
    end

    assign wide      = (depth_cur == DEPTH_32);
    assign pix_count = {16'd0, width_cur} * {16'd0, height_cur};
    assign pix_dec   = pix_left_cur - 32'd1;

    // Per-byte parse step
    always_comb
    begin
        phase_next     = ph_cur;
        pos_next       = pos_cur;
        cmap_type_next = cmap_cur;
        img_type_next  = img_cur;
        width_next     = width_cur;
        height_next    = height_cur;
        depth_next     = depth_cur;
        bip_next       = bip_cur;
        partial_next   = partial_cur;
        pix_left_next  = pix_left_cur;
        emit           = 1'b0;
        key_hit        = 1'b0;

        res            = '0;
        res.width      = width_cur;
        res.height     = height_cur;
        res.depth      = depth_cur;

        case (ph_cur)
            PH_HEADER:
            begin
                case (pos_cur)
                    POS_CMAP_TYPE: cmap_type_next = byte_in;
                    POS_IMG_TYPE:  img_type_next  = byte_in;
                    POS_WIDTH_LO:  width_next     = {width_cur[15:8], byte_in};
                    POS_WIDTH_HI:  width_next     = {byte_in, width_cur[7:0]};
                    POS_HEIGHT_LO: height_next    = {height_cur[15:8], byte_in};
                    POS_HEIGHT_HI: height_next    = {byte_in, height_cur[7:0]};
                    POS_DEPTH:     depth_next     = byte_in;
                    default:       ;
                endcase
                if (pos_cur < POS_JUDGE)
                begin
                    pos_next = pos_cur + 5'd1;
                end
                else if (cmap_cur != CMAP_NONE || img_cur != IMG_TRUECOLOUR)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    res.kind   = KIND_BAD_TYPE;
                    res.last   = 1'b1;
                end
                else if (depth_cur != DEPTH_24 && depth_cur != DEPTH_32)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    res.kind   = KIND_BAD_DEPTH;
                    res.last   = 1'b1;
                end
                else
                begin
                    pix_left_next = pix_count;
                    bip_next      = 2'd0;
                    partial_next  = 24'd0;
                    emit          = 1'b1;
                    res.kind      = KIND_HEADER;
                    res.has_alpha = wide || key_enable_reg;
                    // an empty image has a zero dimension
                    res.last      = (width_cur == 16'd0) || (height_cur == 16'd0);
                    phase_next    = res.last ? PH_IDLE : PH_PIXELS;
                end
            end

            PH_PIXELS:
            begin
                if (wide ? (bip_cur < 2'd3) : (bip_cur < 2'd2))
                begin
                    // merge the byte into the stored B, G, R lanes
                    case (bip_cur)
                        2'd0:    partial_next = partial_cur | {16'd0, byte_in};
                        2'd1:    partial_next = partial_cur | {8'd0, byte_in, 8'd0};
                        2'd2:    partial_next = partial_cur | {byte_in, 16'd0};
                        default: ;
                    endcase
                    bip_next = bip_cur + 2'd1;
                end
                else
                begin
                    emit      = 1'b1;
                    res.kind  = KIND_PIXEL;
                    res.blue  = partial_cur[7:0];
                    res.green = partial_cur[15:8];
                    res.red   = wide ? partial_cur[23:16] : byte_in;
                    if (wide)
                    begin
                        res.alpha     = byte_in;
                        res.has_alpha = 1'b1;
                    end
                    else
                    begin
                        key_hit = key_enable_reg && (byte_in == key_red_reg)
                                  && (partial_cur[15:8] == key_green_reg)
                                  && (partial_cur[7:0] == key_blue_reg);
                        res.alpha     = key_hit ? ALPHA_CLEAR : ALPHA_OPAQUE;
                        res.has_alpha = key_enable_reg;
                    end
                    bip_next      = 2'd0;
                    partial_next  = 24'd0;
                    pix_left_next = pix_dec;
                    res.last      = (pix_dec == 32'd0);
                    if (pix_dec == 32'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end

            default: ;  // idle: drop bytes until the next first flag
        endcase
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 5'd0;
            cmap_type_reg <= 8'd0;
            img_type_reg  <= 8'd0;
            width_reg     <= 16'd0;
            height_reg    <= 16'd0;
            depth_reg     <= 8'd0;
            bip_reg       <= 2'd0;
            partial_reg   <= 24'd0;
            pix_left_reg  <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cmap_type_reg <= cmap_type_next;
            img_type_reg  <= img_type_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            depth_reg     <= depth_next;
            bip_reg       <= bip_next;
            partial_reg   <= partial_next;
            pix_left_reg  <= pix_left_next;
        end
    end

    // Output register: load on a result, clear once the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.has_alpha,
                            out_res_reg.depth,
                            out_res_reg.height,
                            out_res_reg.width,
                            out_res_reg.alpha,
                            out_res_reg.blue,
                            out_res_reg.green,
                            out_res_reg.red};

endmodule

// File: rtl/tgad_checker.sv
// Port-level checker for the TGA true-colour stream decoder, bound to the top.
// Depends on tgad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgad_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tgad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                       m_axis_tuser,
    input logic                             m_axis_tlast
);
    import tgad_pkg::*;

    logic                   is_reject;
    logic                   is_pixel;
    logic                   not_pixel;
    logic                   stalled;
    logic                   depth_ok;
    logic                   out_alpha_flag;
    logic [7:0]             out_depth;
    logic [31:0]            out_colour;
    logic [OUT_TDATA_W+2:0] out_word;

    assign is_reject      = m_axis_tvalid
                            && (m_axis_tuser == KIND_BAD_TYPE
                                || m_axis_tuser == KIND_BAD_DEPTH);
    assign is_pixel       = m_axis_tvalid && (m_axis_tuser == KIND_PIXEL);
    assign not_pixel      = m_axis_tvalid && (m_axis_tuser != KIND_PIXEL);
    assign stalled        = m_axis_tvalid && !m_axis_tready;
    assign out_depth      = m_axis_tdata[71:64];
    assign out_colour     = m_axis_tdata[31:0];
    assign out_alpha_flag = m_axis_tdata[72];
    assign depth_ok       = (out_depth == DEPTH_24) || (out_depth == DEPTH_32);
    assign out_word       = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    // A stalled result holds until taken
    `TGAD_ASSERT_NXT(a_hold_stalled, clk, rst_n, stalled, m_axis_tvalid && $stable(out_word))

    // Header and reject results carry no colour
    `TGAD_ASSERT_IMP(a_no_colour, clk, rst_n, not_pixel, out_colour == 32'd0)

    // A reject ends the file and reports no alpha
    `TGAD_ASSERT_IMP(a_reject_last, clk, rst_n, is_reject, m_axis_tlast && !out_alpha_flag)

    // Pixels of a 32-bit image always carry alpha
    `TGAD_ASSERT_IMP(a_wide_alpha, clk, rst_n, is_pixel && out_depth == DEPTH_32, out_alpha_flag)

    // A pixel result only comes from an image of a legal depth
    `TGAD_ASSERT_IMP(a_pixel_depth, clk, rst_n, is_pixel, depth_ok)

endmodule

bind tga_truecolor_stream_decoder_core tgad_checker u_tgad_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: sim/tga_decode_checker.sv
// Checker for the TGA true-colour stream decoder: watches the configuration
// port and both stream sides, decodes every byte transfer and compares results.
// Depends on tgad_pkg.
module tga_decode_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [tgad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [1:0]                       m_axis_tuser,
    input  logic                             m_axis_tlast,
    output int                               mismatches,
    output int                               results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tgad_pkg::*;

    // colour key registers
    logic        key_on;
    logic [7:0]  key_r;
    logic [7:0]  key_g;
    logic [7:0]  key_b;

    // parse state
    logic [1:0]  phase;
    logic [4:0]  hdr_pos;
    logic [7:0]  cmap_type;
    logic [7:0]  img_type;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  img_depth;
    logic [1:0]  pix_byte;
    logic [23:0] pix_acc;
    logic [31:0] pix_left;

    result_t     decoded_results[$];
    int          fail_total = 0;

    assign mismatches = fail_total;

    task automatic clear_parse();
        phase     = PH_HEADER;
        hdr_pos   = '0;
        cmap_type = '0;
        img_type  = '0;
        img_w     = '0;
        img_h     = '0;
        img_depth = '0;
        pix_byte  = '0;
        pix_acc   = '0;
        pix_left  = '0;
    endtask

    function automatic result_t form_result(logic [1:0] kind, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] a, logic ha,
                                            logic fin);
        result_t res;
        res.kind      = kind;
        res.red       = r;
        res.green     = g;
        res.blue      = b;
        res.alpha     = a;
        res.width     = img_w;
        res.height    = img_h;
        res.depth     = img_depth;
        res.has_alpha = ha;
        res.last      = fin;
        return res;
    endfunction

    // Advance the parser by one file byte; queue the result it completes, if any.
    task automatic decode_byte(input logic [7:0] value, input logic first_flag);
        logic       wide;
        logic [1:0] need;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       ha;
        if (first_flag)
            clear_parse();
        if (phase == PH_HEADER)
        begin
            case (hdr_pos)
                POS_CMAP_TYPE: cmap_type = value;
                POS_IMG_TYPE:  img_type = value;
                POS_WIDTH_LO:  img_w[7:0] = value;
                POS_WIDTH_HI:  img_w[15:8] = value;
                POS_HEIGHT_LO: img_h[7:0] = value;
                POS_HEIGHT_HI: img_h[15:8] = value;
                POS_DEPTH:     img_depth = value;
                default: ;
            endcase
            if (hdr_pos < POS_JUDGE)
                hdr_pos = hdr_pos + 5'd1;
            else if (cmap_type != CMAP_NONE || img_type != IMG_TRUECOLOUR)
            begin
                phase = PH_IDLE;
                decoded_results.push_back(form_result(KIND_BAD_TYPE, 8'd0, 8'd0, 8'd0,
                                                      8'd0, 1'b0, 1'b1));
            end
            else if (img_depth != DEPTH_24 && img_depth != DEPTH_32)
            begin
                phase = PH_IDLE;
                decoded_results.push_back(form_result(KIND_BAD_DEPTH, 8'd0, 8'd0, 8'd0,
                                                      8'd0, 1'b0, 1'b1));
            end
            else
            begin
                pix_left = {16'd0, img_w} * {16'd0, img_h};
                pix_byte = '0;
                pix_acc  = '0;
                ha       = (img_depth == DEPTH_32) || key_on;
                phase    = (pix_left == 32'd0) ? PH_IDLE : PH_PIXELS;
                decoded_results.push_back(form_result(KIND_HEADER, 8'd0, 8'd0, 8'd0, 8'd0,
                                                      ha, pix_left == 32'd0));
            end
        end
        else if (phase == PH_PIXELS)
        begin
            wide = (img_depth == DEPTH_32);
            need = wide ? 2'd3 : 2'd2;
            if (pix_byte < need)
            begin
                pix_acc  = pix_acc | (24'(value) << (8 * pix_byte));
                pix_byte = pix_byte + 2'd1;
            end
            else
            begin
                if (!wide)
                    pix_acc[23:16] = value;
                b = pix_acc[7:0];
                g = pix_acc[15:8];
                r = pix_acc[23:16];
                if (wide)
                begin
                    a  = value;
                    ha = 1'b1;
                end
                else
                begin
                    a  = (key_on && r == key_r && g == key_g && b == key_b) ?
                         ALPHA_CLEAR : ALPHA_OPAQUE;
                    ha = key_on;
                end
                pix_byte = '0;
                pix_acc  = '0;
                pix_left = pix_left - 32'd1;
                if (pix_left == 32'd0)
                    phase = PH_IDLE;
                decoded_results.push_back(form_result(KIND_PIXEL, r, g, b, a, ha,
                                                      pix_left == 32'd0));
            end
        end
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", label, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            key_on = 1'b0;
            key_r  = '0;
            key_g  = '0;
            key_b  = '0;
            clear_parse();
            decoded_results.delete();
        end
        else
        begin
            // Output side first: a byte never completes a result in its own cycle.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, tdata %0h", m_axis_tuser,
                           m_axis_tdata);
                    fail_total++;
                end
                else
                begin
                    want = decoded_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
                    check_field("red", 16'(want.red), 16'(m_axis_tdata[7:0]));
                    check_field("green", 16'(want.green), 16'(m_axis_tdata[15:8]));
                    check_field("blue", 16'(want.blue), 16'(m_axis_tdata[23:16]));
                    check_field("alpha", 16'(want.alpha), 16'(m_axis_tdata[31:24]));
                    check_field("width", want.width, m_axis_tdata[47:32]);
                    check_field("height", want.height, m_axis_tdata[63:48]);
                    check_field("depth", 16'(want.depth), 16'(m_axis_tdata[71:64]));
                    check_field("has_alpha", 16'(want.has_alpha), 16'(m_axis_tdata[72]));
                    check_field("last", 16'(want.last), 16'(m_axis_tlast));
                end
            end
            // A byte taken at this edge still sees the key from before the write.
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tuser);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_ENABLE: key_on = cfg_data[0];
                    CFG_KEY_RED:    key_r = cfg_data;
                    CFG_KEY_GREEN:  key_g = cfg_data;
                    CFG_KEY_BLUE:   key_b = cfg_data;
                    default: ;
                endcase
            end
        end
        results_pending <= decoded_results.size();
    end

endmodule

// File: sim/tb_top.sv
// Top of the decoder testbench: clock, reset, file byte stimulus, colour key
// programming and the output-side receiver. Depends on tgad_pkg, the decoder
// core and tga_decode_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tgad_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = CFG_KEY_ENABLE;
    logic [7:0]              cfg_data = 8'd0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = 8'd0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]              m_axis_tuser;
    logic                    m_axis_tlast;

    int                      mismatches;
    int                      results_pending;

    // Stimulus-side copy of the key colour, used only to aim pixel colours at it.
    logic [7:0]              key_r = 8'd0;
    logic [7:0]              key_g = 8'd0;
    logic [7:0]              key_b = 8'd0;

    // Written by the stimulus with nonblocking assignments, read by the receiver.
    logic                    steady = 1'b0;        // no idling on either side
    int                      hold_requests = 0;    // long receiver hold-offs asked for

    int                      bytes_sent = 0;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 29;

    always #1 clk = ~clk;

    tga_truecolor_stream_decoder_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tga_decode_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // Receiver: random back-pressure, none while steady, and a long hold-off
    // counted here whenever the stimulus asks for one. The sender keeps
    // offering bytes meanwhile, so the output register fills and the input stalls.
    initial
    begin
        int hold_served;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one byte and hold it until the transfer; random gaps before it.
    // tvalid is left high so back-to-back bytes need only one assignment a step.
    task automatic send_byte(input logic [7:0] value, input logic first_flag);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= first_flag;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stray bytes without a first flag; dropped by the block once it is idle.
    task automatic send_noise(input int count);
        repeat (count)
            send_byte(8'($urandom), 1'b0);
    endtask

    // One file: hdr_len header bytes (18 for a whole header, fewer to cut it
    // short), then pix_bytes of BGR or BGRA data. Colours land on the key,
    // on the component extremes or anywhere.
    task automatic send_file(input logic lead_first, input logic [7:0] cmap,
                             input logic [7:0] img, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] bpp,
                             input int hdr_len, input int pix_bytes);
        logic [7:0] hdr_byte;
        logic [7:0] pr;
        logic [7:0] pg;
        logic [7:0] pb;
        logic [7:0] pa;
        int         per_pixel;
        int         sel;
        per_pixel = (bpp == DEPTH_32) ? 4 : 3;
        for (int i = 0; i < hdr_len; i++)
        begin
            case (5'(i))
                POS_CMAP_TYPE: hdr_byte = cmap;
                POS_IMG_TYPE:  hdr_byte = img;
                POS_WIDTH_LO:  hdr_byte = w[7:0];
                POS_WIDTH_HI:  hdr_byte = w[15:8];
                POS_HEIGHT_LO: hdr_byte = h[7:0];
                POS_HEIGHT_HI: hdr_byte = h[15:8];
                POS_DEPTH:     hdr_byte = bpp;
                default:       hdr_byte = 8'($urandom);
            endcase
            send_byte(hdr_byte, (i == 0) && lead_first);
        end
        for (int j = 0; j < pix_bytes; j++)
        begin
            if (j % per_pixel == 0)
            begin
                sel = $urandom_range(9);
                if (sel < 3)
                begin
                    pr = key_r;
                    pg = key_g;
                    pb = key_b;
                end
                else if (sel < 5)
                begin
                    pr = $urandom_range(1) ? 8'hFF : 8'h00;
                    pg = $urandom_range(1) ? 8'hFF : 8'h00;
                    pb = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                else
                begin
                    pr = 8'($urandom);
                    pg = 8'($urandom);
                    pb = 8'($urandom);
                end
                sel = $urandom_range(3);
                pa  = (sel == 0) ? ALPHA_CLEAR : (sel == 1) ? ALPHA_OPAQUE : 8'($urandom);
            end
            case (j % per_pixel)
                0:       send_byte(pb, 1'b0);
                1:       send_byte(pg, 1'b0);
                2:       send_byte(pr, 1'b0);
                default: send_byte(pa, 1'b0);
            endcase
        end
        bytes_sent += hdr_len + pix_bytes;
    endtask

    // Drop tvalid and wait until every predicted result has been taken, then
    // let the output register drain.
    task automatic settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Program all four key registers; only bit 0 of the enable value counts.
    task automatic program_key(input logic [7:0] en, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        write_reg(CFG_KEY_ENABLE, en);
        write_reg(CFG_KEY_RED, r);
        write_reg(CFG_KEY_GREEN, g);
        write_reg(CFG_KEY_BLUE, b);
        key_r = r;
        key_g = g;
        key_b = b;
    endtask

    function automatic logic [7:0] key_level();
        int sel;
        sel = $urandom_range(3);
        return (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int          file_no;
        int          pick;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  bpp;
        logic [7:0]  cmap;
        logic [7:0]  img;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Stream opens without a first flag: parse from the reset state.
        send_file(1'b0, CMAP_NONE, IMG_TRUECOLOUR, 16'd1, 16'd1, DEPTH_24, 18, 3);
        // Both type checks fail (depth bad too): bad type wins; trailing bytes dropped.
        send_file(1'b1, 8'hFF, 8'h00, 16'd2, 16'd2, 8'h10, 18, 2);
        // Good type, bad depth.
        send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'd1, 16'd1, 8'hFF, 18, 0);
        settle();
        program_key(8'h01, 8'hFF, 8'h00, 8'hFF);
        // 24-bit with the key enabled, then 32-bit with the file's own alpha.
        send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'd3, 16'd1, DEPTH_24, 18, 9);
        send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'd2, 16'd1, DEPTH_32, 18, 8);
        // Empty image: last on the header, then bytes after it are dropped.
        send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'h0100, 16'd0, DEPTH_32, 18, 0);
        send_noise(2);
        // Largest image, cut short after two and a bit pixels by the next file.
        send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'hFFFF, 16'hFFFF, DEPTH_32, 18, 9);
        // Header abandoned part-way by a restart.
        send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'd1, 16'd1, DEPTH_24, 7, 0);
        settle();
        // Odd enable value: masked to bit 0, so the key is off.
        program_key(8'hFE, 8'h00, 8'hFF, 8'h00);

        // Random part: mostly well-formed small files, some rejects and breaks.
        file_no = 0;
        while (bytes_sent < 1550)
        begin
            if (file_no % 20 == 19)
            begin
                settle();
                program_key(($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(1)),
                            key_level(), key_level(), key_level());
            end
            if (file_no == 10 || file_no == 38)
                hold_requests <= hold_requests + 1;
            if (file_no == 20)
                steady <= 1'b1;
            if (file_no == 34)
                steady <= 1'b0;

            pick = $urandom_range(99);
            w    = 16'($urandom_range(5));
            h    = 16'($urandom_range(4));
            bpp  = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
            if (pick < 70)
            begin
                send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, w, h, bpp, 18,
                          int'(w) * int'(h) * ((bpp == DEPTH_32) ? 4 : 3));
            end
            else if (pick < 78)
            begin
                cmap = 8'($urandom_range(3) == 0 ? CMAP_NONE : 8'($urandom));
                img  = 8'($urandom);
                if (cmap == CMAP_NONE && img == IMG_TRUECOLOUR)
                    img = 8'h0A;
                send_file(1'b1, cmap, img, w, h, bpp, 18, $urandom_range(6));
            end
            else if (pick < 85)
            begin
                bpp = 8'($urandom);
                if (bpp == DEPTH_24 || bpp == DEPTH_32)
                    bpp = 8'd16;
                send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, w, h, bpp, 18, $urandom_range(6));
            end
            else if (pick < 93)
            begin
                // Big image truncated by the next first flag.
                send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 65535)), bpp, 18, $urandom_range(20));
            end
            else
            begin
                send_file(1'b1, CMAP_NONE, IMG_TRUECOLOUR, w, h, bpp,
                          $urandom_range(1, 17), 0);
            end
            if ($urandom_range(9) == 0)
                send_noise($urandom_range(1, 5));
            file_no++;
        end

        settle();
        if (mismatches == 0 && results_pending == 0)
            $display("PASS tga_truecolor_stream_decoder_core");
        else
            $display("FAIL tga_truecolor_stream_decoder_core");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAIL tga_truecolor_stream_decoder_core");
        $finish;
    end

endmodule
